>>> design/me_pkg.sv
// Shared constants for the modular exponentiation pipeline.
// No dependencies.
`timescale 1ns / 1ps
package me_pkg;
    localparam int BASE_W       = 31;           // width of the base field
    localparam int EXP_BITS_DEF = 32;           // default exponent width
    localparam int MOD_BITS_DEF = 31;           // default modulus width
    localparam longint unsigned MODULUS_RST = 64'd2147483647;
endpackage

>>> design/me_reduce.sv
// Base reduction pipeline: base mod m, one bit of the base per stage.
// Uses me_pkg.
`timescale 1ns / 1ps
module me_reduce #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [MOD_BITS-1:0] i_m,
    input  logic                i_valid,
    input  logic [me_pkg::BASE_W-1:0] i_base,
    input  logic [EXP_BITS-1:0] i_exp,
    output logic                o_valid,
    output logic [EXP_BITS-1:0] o_exp,
    output logic [MOD_BITS-1:0] o_pw
);
    import me_pkg::*;

    logic                r_v    [BASE_W];
    logic [BASE_W-1:0]   r_base [BASE_W];
    logic [EXP_BITS-1:0] r_e    [BASE_W];
    logic [MOD_BITS-1:0] r_r    [BASE_W];

    // shift in one base bit, subtract m once if needed
    function automatic logic [MOD_BITS-1:0] rstep(input logic [MOD_BITS-1:0] r,
                                                  input logic b,
                                                  input logic [MOD_BITS-1:0] m);
        logic [MOD_BITS:0] d;
        d = {r, b};
        if (d >= {1'b0, m}) d = d - {1'b0, m};
        return d[MOD_BITS-1:0];
    endfunction

    genvar j;
    generate
        for (j = 0; j < BASE_W; j++) begin : g_stage
            logic                n_v;
            logic [BASE_W-1:0]   n_base;
            logic [EXP_BITS-1:0] n_e;
            logic [MOD_BITS-1:0] n_r;
            if (j == 0) begin : g_first
                assign n_v    = i_valid;
                assign n_base = i_base;
                assign n_e    = i_exp;
                assign n_r    = rstep('0, i_base[BASE_W-1], i_m);
            end else begin : g_next
                assign n_v    = r_v[j-1];
                assign n_base = r_base[j-1];
                assign n_e    = r_e[j-1];
                assign n_r    = rstep(r_r[j-1], r_base[j-1][BASE_W-1-j], i_m);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= n_v;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_base[j] <= n_base;
                    r_e[j]    <= n_e;
                    r_r[j]    <= n_r;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[BASE_W-1];
    assign o_exp   = r_e[BASE_W-1];
    assign o_pw    = r_r[BASE_W-1];
endmodule

>>> design/me_pass.sv
// One exponent bit: acc*pw and pw*pw mod m, bit-serial, one multiplier bit per stage.
// Standalone; instantiated by the top level.
`timescale 1ns / 1ps
module me_pass #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [MOD_BITS-1:0] i_m,
    input  logic                i_valid,
    input  logic [EXP_BITS-1:0] i_exp,
    input  logic [MOD_BITS-1:0] i_acc,
    input  logic [MOD_BITS-1:0] i_pw,
    output logic                o_valid,
    output logic [EXP_BITS-1:0] o_exp,
    output logic [MOD_BITS-1:0] o_acc,
    output logic [MOD_BITS-1:0] o_pw
);
    logic                r_v   [MOD_BITS];
    logic [EXP_BITS-1:0] r_e   [MOD_BITS];
    logic [MOD_BITS-1:0] r_acc [MOD_BITS];
    logic [MOD_BITS-1:0] r_pw  [MOD_BITS];
    logic [MOD_BITS-1:0] r_ra  [MOD_BITS];
    logic [MOD_BITS-1:0] r_rp  [MOD_BITS];

    // r = 2r mod m, then add a mod m when b is set; a < m, r < m
    function automatic logic [MOD_BITS-1:0] mstep(input logic [MOD_BITS-1:0] r,
                                                  input logic [MOD_BITS-1:0] a,
                                                  input logic b,
                                                  input logic [MOD_BITS-1:0] m);
        logic [MOD_BITS:0] d;
        logic [MOD_BITS:0] s;
        d = {r, 1'b0};
        if (d >= {1'b0, m}) d = d - {1'b0, m};
        s = d + (b ? {1'b0, a} : '0);
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[MOD_BITS-1:0];
    endfunction

    genvar j;
    generate
        for (j = 0; j < MOD_BITS; j++) begin : g_stage
            logic                n_v;
            logic [EXP_BITS-1:0] n_e;
            logic [MOD_BITS-1:0] n_acc;
            logic [MOD_BITS-1:0] n_pw;
            logic [MOD_BITS-1:0] n_ra;
            logic [MOD_BITS-1:0] n_rp;
            if (j == 0) begin : g_first
                assign n_v   = i_valid;
                assign n_e   = i_exp;
                assign n_acc = i_acc;
                assign n_pw  = i_pw;
                assign n_ra  = mstep('0, i_pw, i_acc[MOD_BITS-1], i_m);
                assign n_rp  = mstep('0, i_pw, i_pw[MOD_BITS-1], i_m);
            end else begin : g_next
                assign n_v   = r_v[j-1];
                assign n_e   = r_e[j-1];
                assign n_acc = r_acc[j-1];
                assign n_pw  = r_pw[j-1];
                assign n_ra  = mstep(r_ra[j-1], r_pw[j-1], r_acc[j-1][MOD_BITS-1-j], i_m);
                assign n_rp  = mstep(r_rp[j-1], r_pw[j-1], r_pw[j-1][MOD_BITS-1-j], i_m);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= n_v;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_e[j]   <= n_e;
                    r_acc[j] <= n_acc;
                    r_pw[j]  <= n_pw;
                    r_ra[j]  <= n_ra;
                    r_rp[j]  <= n_rp;
                end
            end
        end
    endgenerate

    // acc is only replaced when this exponent bit is set
    assign o_valid = r_v[MOD_BITS-1];
    assign o_exp   = r_e[MOD_BITS-1] >> 1;
    assign o_acc   = r_e[MOD_BITS-1][0] ? r_ra[MOD_BITS-1] : r_acc[MOD_BITS-1];
    assign o_pw    = r_rp[MOD_BITS-1];
endmodule

>>> design/modular_exponentiation.sv
// Top level of the modular exponentiation pipeline.
// Uses me_pkg, me_reduce and me_pass.
`timescale 1ns / 1ps
// Computes base^exponent mod modulus by the right-to-left binary method, fully
// unrolled into a pipeline that takes one request per clock and returns one
// result per request, in order. The modulus sits in a configuration register
// (reset 2^31-1) and should only be written while no request is in flight.
// 31 stages reduce the base one bit at a time, then each exponent bit gets MOD_BITS
// stages of bit-serial shift/add/subtract modular multiplication, doing the
// conditional accumulator update and the squaring side by side, then one
// output register. Throughput is one request per cycle; a stall on the output
// freezes the whole pipeline and stalls the input. A zero exponent gives 1 for
// any nonzero modulus; a modulus of zero gives 0.
module modular_exponentiation #(
    parameter int EXP_BITS = me_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = me_pkg::MOD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [MOD_BITS-1:0]       i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [me_pkg::BASE_W-1:0] i_base,
    input  logic [EXP_BITS-1:0]       i_exponent,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [MOD_BITS-1:0]       o_result
);
    import me_pkg::*;

    logic [MOD_BITS-1:0] r_modulus;
    logic                r_ov;
    logic [MOD_BITS-1:0] r_res;
    logic                w_adv;

    // chain between passes: index k feeds pass k
    logic                w_v   [EXP_BITS+1];
    logic [EXP_BITS-1:0] w_e   [EXP_BITS+1];
    logic [MOD_BITS-1:0] w_acc [EXP_BITS+1];
    logic [MOD_BITS-1:0] w_pw  [EXP_BITS+1];

    // single global enable: everything moves unless the held result is stalled
    assign w_adv       = !r_ov || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_BITS'(MODULUS_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_modulus <= i_cfg_data;
        end
    end

    me_reduce #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_m     (r_modulus),
        .i_valid (i_in_valid),
        .i_base  (i_base),
        .i_exp   (i_exponent),
        .o_valid (w_v[0]),
        .o_exp   (w_e[0]),
        .o_pw    (w_pw[0])
    );

    // accumulator starts at 1 and is never reduced on its own
    assign w_acc[0] = MOD_BITS'(1);

    genvar k;
    generate
        for (k = 0; k < EXP_BITS; k++) begin : g_pass
            me_pass #(
                .EXP_BITS (EXP_BITS),
                .MOD_BITS (MOD_BITS)
            ) u_pass (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_adv),
                .i_m     (r_modulus),
                .i_valid (w_v[k]),
                .i_exp   (w_e[k]),
                .i_acc   (w_acc[k]),
                .i_pw    (w_pw[k]),
                .o_valid (w_v[k+1]),
                .o_exp   (w_e[k+1]),
                .o_acc   (w_acc[k+1]),
                .o_pw    (w_pw[k+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_v[EXP_BITS];
        end
    end

    // zero modulus: nothing to divide by, result is 0
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= (r_modulus == '0) ? '0 : w_acc[EXP_BITS];
        end
    end

    assign o_out_valid = r_ov;
    assign o_result    = r_res;

`ifndef NO_ASSERTIONS
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");
    a_frozen_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(w_v[EXP_BITS]) && $stable(w_acc[EXP_BITS]))
        else $error("pipeline moved during output stall");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(o_result) && o_out_valid)
        else $error("held result changed during stall");
`endif
endmodule
